/* sv/fit_policy_block_allocator_assert.svh */
// Assertion macros for the block allocator.
`ifndef FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIT_POLICY_BLOCK_ALLOCATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define FPBA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
`define FPBA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define FPBA_ASSERT_SAME(label, ante, cons)
`define FPBA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/fpba_pkg.sv */
`default_nettype none
package fpba_pkg;

  localparam int BLOCKS  = 64;
  localparam int IDX_W   = $clog2(BLOCKS);
  localparam int CAP_W   = 16;
  localparam int BIU_W   = 7;
  localparam int POL_W   = 2;
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [BIU_W-1:0] BIU_RESET = BIU_W'(64);

  typedef enum logic [POL_W-1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2
  } fit_policy_e;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_REQUEST = 1'b1
  } item_kind_e;

  typedef enum logic {
    REG_BLOCKS_IN_USE = 1'b0,
    REG_FIT_POLICY    = 1'b1
  } reg_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

endpackage
`default_nettype wire

/* sv/fpba_cell.sv */
`default_nettype none
module fpba_cell (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire  fpba_pkg::cell_ctrl_t   ctrl_i,
  input  wire  [fpba_pkg::CAP_W-1:0]   wdata_i,
  input  wire  [fpba_pkg::CAP_W-1:0]   shift_in_i,
  output logic [fpba_pkg::CAP_W-1:0]   cap_o
);

  logic [fpba_pkg::CAP_W-1:0] cap_d, cap_q;

  // A direct write wins over the ring shift; the control never asks for both.
  always_comb begin
    cap_d = cap_q;
    if (ctrl_i.write) begin
      cap_d = wdata_i;
    end else if (ctrl_i.shift) begin
      cap_d = shift_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= '0;
    end else begin
      cap_q <= cap_d;
    end
  end

  assign cap_o = cap_q;

endmodule
`default_nettype wire

/* sv/fit_policy_block_allocator.sv */
// Load items give no result; one can follow every cycle while the block is idle.
// A request holds the block for an accept step, a scan in which the ring of capacity
// cells rotates once past the compare at cell 0, and a write-back step. The result
// is registered in the write-back step, and the next item is taken in the cycle after
// the write-back. A result still waiting in the output register holds the write-back.
// Reset (rst_ni low, asynchronous) clears all capacities to zero, blocks in use to
// 64 and the policy to first fit.
`default_nettype none
`include "fit_policy_block_allocator_assert.svh"
module fit_policy_block_allocator (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration port
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire  [fpba_pkg::ADDR_W-1:0]    paddr,
  input  wire  [fpba_pkg::DATA_W-1:0]    pwdata,
  output logic [fpba_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  // input items
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            kind_i,
  input  wire  [5:0]                     load_index_i,
  input  wire  [fpba_pkg::CAP_W-1:0]     load_capacity_i,
  input  wire  [fpba_pkg::CAP_W-1:0]     request_size_i,
  input  wire                            last_request_i,
  // result items
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           allocated_o,
  output logic [5:0]                     granted_block_o,
  output logic [fpba_pkg::CAP_W-1:0]     capacity_left_o,
  output logic                           last_result_o
);

  localparam int N = fpba_pkg::BLOCKS;
  localparam int IW = fpba_pkg::IDX_W;
  localparam int CW = fpba_pkg::CAP_W;

  // Configuration registers
  logic [fpba_pkg::BIU_W-1:0] biu_q;
  logic [fpba_pkg::POL_W-1:0] policy_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      biu_q    <= fpba_pkg::BIU_RESET;
      policy_q <= fpba_pkg::FIT_FIRST;
    end else if (cfg_wr) begin
      case (fpba_pkg::reg_sel_e'(paddr[2]))
        fpba_pkg::REG_BLOCKS_IN_USE: biu_q    <= pwdata[fpba_pkg::BIU_W-1:0];
        fpba_pkg::REG_FIT_POLICY:    policy_q <= pwdata[fpba_pkg::POL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (fpba_pkg::reg_sel_e'(paddr[2]))
      fpba_pkg::REG_BLOCKS_IN_USE:
        prdata = fpba_pkg::DATA_W'(biu_q);
      fpba_pkg::REG_FIT_POLICY:
        prdata = fpba_pkg::DATA_W'(policy_q);
      default:
        prdata = '0;
    endcase
  end

  // Control state
  fpba_pkg::state_e  state_q, state_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic              found_q, found_d;
  logic [IW-1:0]     pick_q, pick_d;
  logic [CW-1:0]     best_q, best_d;
  logic [CW-1:0]     size_q, size_d;
  logic              last_q, last_d;

  logic              ov_q, ov_d;
  logic              oalloc_q, oalloc_d;
  logic [5:0]        oblk_q, oblk_d;
  logic [CW-1:0]     ocap_q, ocap_d;
  logic              olast_q, olast_d;

  logic              shift_en;
  logic              wr_en;
  logic [IW-1:0]     wr_idx;
  logic [CW-1:0]     wr_data;
  logic [CW-1:0]     cap [N];
  logic [CW-1:0]     head;
  logic              candidate;
  logic              better;
  logic              out_free;

  assign head      = cap[0];
  assign out_free  = !ov_q || out_ready_i;
  assign candidate = (fpba_pkg::BIU_W'(cnt_q) < biu_q) && (head >= size_q);

  always_comb begin
    case (fpba_pkg::fit_policy_e'(policy_q))
      fpba_pkg::FIT_BEST:  better = head < best_q;
      fpba_pkg::FIT_WORST: better = head > best_q;
      default:             better = 1'b0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    found_d  = found_q;
    pick_d   = pick_q;
    best_d   = best_q;
    size_d   = size_q;
    last_d   = last_q;
    ov_d     = ov_q && !out_ready_i;
    oalloc_d = oalloc_q;
    oblk_d   = oblk_q;
    ocap_d   = ocap_q;
    olast_d  = olast_q;
    shift_en = 1'b0;
    wr_en    = 1'b0;
    wr_idx   = load_index_i[IW-1:0];
    wr_data  = load_capacity_i;
    in_ready_o = 1'b0;

    case (state_q)
      fpba_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (fpba_pkg::item_kind_e'(kind_i) == fpba_pkg::KIND_LOAD) begin
            wr_en = 1'b1;
          end else begin
            size_d  = request_size_i;
            last_d  = last_request_i;
            found_d = 1'b0;
            pick_d  = '0;
            best_d  = '0;
            cnt_d   = '0;
            state_d = fpba_pkg::ST_SCAN;
          end
        end
      end
      fpba_pkg::ST_SCAN: begin
        // Block cnt_q sits in cell 0; the ring rotates once per cycle.
        shift_en = 1'b1;
        if (candidate && (!found_q || better)) begin
          found_d = 1'b1;
          pick_d  = cnt_q;
          best_d  = head;
        end
        cnt_d = cnt_q + IW'(1);
        if (cnt_q == IW'(N - 1)) begin
          state_d = fpba_pkg::ST_WRITE;
        end
      end
      fpba_pkg::ST_WRITE: begin
        // After a full turn the ring is back in place; write back and report.
        wr_idx  = pick_q;
        wr_data = best_q - size_q;
        if (out_free) begin
          wr_en    = found_q;
          ov_d     = 1'b1;
          oalloc_d = found_q;
          oblk_d   = found_q ? 6'(pick_q) : 6'd0;
          ocap_d   = found_q ? (best_q - size_q) : '0;
          olast_d  = last_q;
          state_d  = fpba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fpba_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpba_pkg::ST_IDLE;
      cnt_q   <= '0;
      found_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      found_q <= found_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q   <= pick_d;
    best_q   <= best_d;
    size_q   <= size_d;
    last_q   <= last_d;
    oalloc_q <= oalloc_d;
    oblk_q   <= oblk_d;
    ocap_q   <= ocap_d;
    olast_q  <= olast_d;
  end

  // Ring of capacity cells: cell i takes the value of cell i+1 on a shift.
  for (genvar i = 0; i < N; i++) begin : g_cell
    fpba_pkg::cell_ctrl_t ctrl;

    assign ctrl = '{shift: shift_en, write: wr_en && (wr_idx == IW'(i))};

    fpba_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .wdata_i    (wr_data),
      .shift_in_i (cap[(i + 1) % N]),
      .cap_o      (cap[i])
    );
  end

  assign out_valid_o     = ov_q;
  assign allocated_o     = oalloc_q;
  assign granted_block_o = oblk_q;
  assign capacity_left_o = ocap_q;
  assign last_result_o   = olast_q;

  `FPBA_ASSERT_SAME(a_result_after_write, $rose(ov_q), $past(state_q) == fpba_pkg::ST_WRITE)
  `FPBA_ASSERT_SAME(a_miss_is_zero, ov_q && !oalloc_q, oblk_q == 6'd0 && ocap_q == '0)
  `FPBA_ASSERT_NEXT(a_scan_ends, state_q == fpba_pkg::ST_SCAN && cnt_q == IW'(N - 1),
                    state_q == fpba_pkg::ST_WRITE)
  `FPBA_ASSERT_SAME(a_no_take_busy, state_q != fpba_pkg::ST_IDLE, !in_ready_o)

endmodule
`default_nettype wire

/* tb/fit_policy_block_allocator_test.sv */
`default_nettype none
module fit_policy_block_allocator_test;

  localparam int DRAIN_CYCLES = 70;
  localparam logic [fpba_pkg::POL_W-1:0] FIT_UNUSED = 2'd3;
  localparam logic [fpba_pkg::ADDR_W-1:0] BIU_ADDR = {fpba_pkg::REG_BLOCKS_IN_USE, 2'b00};
  localparam logic [fpba_pkg::ADDR_W-1:0] POLICY_ADDR = {fpba_pkg::REG_FIT_POLICY, 2'b00};

  typedef struct packed {
    logic                       allocated;
    logic [5:0]                 block;
    logic [fpba_pkg::CAP_W-1:0] cap_left;
    logic                       last;
  } grant_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [fpba_pkg::ADDR_W-1:0] paddr = '0;
  logic [fpba_pkg::DATA_W-1:0] pwdata = '0;
  wire  [fpba_pkg::DATA_W-1:0] prdata;
  wire                         pready;

  logic                       in_valid = 1'b0;
  wire                        in_ready_o;
  fpba_pkg::item_kind_e       in_kind = fpba_pkg::KIND_LOAD;
  logic [5:0]                 in_load_index = '0;
  logic [fpba_pkg::CAP_W-1:0] in_load_capacity = '0;
  logic [fpba_pkg::CAP_W-1:0] in_request_size = '0;
  logic                       in_last = 1'b0;

  wire                        out_valid_o;
  logic                       out_ready = 1'b0;
  wire                        allocated_o;
  wire  [5:0]                 granted_block_o;
  wire  [fpba_pkg::CAP_W-1:0] capacity_left_o;
  wire                        last_result_o;

  // Model of the capacity table and of the two registers.
  logic [fpba_pkg::CAP_W-1:0] capacity_model [fpba_pkg::BLOCKS];
  logic [fpba_pkg::BIU_W-1:0] model_blocks_in_use = fpba_pkg::BIU_RESET;
  logic [fpba_pkg::POL_W-1:0] model_policy = fpba_pkg::FIT_FIRST;
  grant_t                     expected_grants [$];

  int  errors = 0;
  int  random_items = 0;
  int  stall_left = 0;
  bit  quiet_tail = 1'b0;

  fit_policy_block_allocator DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .kind_i          (in_kind),
    .load_index_i    (in_load_index),
    .load_capacity_i (in_load_capacity),
    .request_size_i  (in_request_size),
    .last_request_i  (in_last),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .allocated_o     (allocated_o),
    .granted_block_o (granted_block_o),
    .capacity_left_o (capacity_left_o),
    .last_result_o   (last_result_o)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("fit_policy_block_allocator verification failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    errors++;
  endtask

  // Updates the table for a load, or picks a block for a request and queues its grant.
  function automatic void predict_allocation(input fpba_pkg::item_kind_e kind,
                                             input logic [5:0] idx,
                                             input logic [fpba_pkg::CAP_W-1:0] cap,
                                             input logic [fpba_pkg::CAP_W-1:0] size,
                                             input logic last);
    int     scan;
    int     pick;
    bit     found;
    grant_t g;
    found = 1'b0;
    pick = 0;
    if (kind == fpba_pkg::KIND_LOAD) begin
      capacity_model[idx] = cap;
      return;
    end
    scan = (model_blocks_in_use > fpba_pkg::BLOCKS) ? fpba_pkg::BLOCKS
                                                    : int'(model_blocks_in_use);
    for (int j = 0; j < scan; j++) begin
      if (capacity_model[j] < size) continue;
      if (!found) begin
        found = 1'b1;
        pick = j;
        if (model_policy != fpba_pkg::FIT_BEST && model_policy != fpba_pkg::FIT_WORST) break;
      end else if (model_policy == fpba_pkg::FIT_BEST) begin
        if (capacity_model[j] < capacity_model[pick]) pick = j;
      end else if (model_policy == fpba_pkg::FIT_WORST) begin
        if (capacity_model[j] > capacity_model[pick]) pick = j;
      end
    end
    g = '0;
    g.last = last;
    if (found) begin
      capacity_model[pick] = capacity_model[pick] - size;
      g.allocated = 1'b1;
      g.block = pick[5:0];
      g.cap_left = capacity_model[pick];
    end
    expected_grants.push_back(g);
  endfunction

  task automatic check_grant();
    grant_t want;
    if (expected_grants.size() == 0) begin
      report_mismatch("result with no request pending");
      return;
    end
    want = expected_grants.pop_front();
    if (allocated_o !== want.allocated)
      report_mismatch($sformatf("allocated got %0b expected %0b", allocated_o, want.allocated));
    if (granted_block_o !== want.block)
      report_mismatch($sformatf("granted_block got %0d expected %0d",
                                granted_block_o, want.block));
    if (capacity_left_o !== want.cap_left)
      report_mismatch($sformatf("capacity_left got %0d expected %0d",
                                capacity_left_o, want.cap_left));
    if (last_result_o !== want.last)
      report_mismatch($sformatf("last_result got %0b expected %0b", last_result_o, want.last));
  endtask

  // Both channels are watched at the rising edge; inputs only change on the falling edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o === 1'b1)
        predict_allocation(in_kind, in_load_index, in_load_capacity, in_request_size, in_last);
      if (out_valid_o === 1'b1 && out_ready)
        check_grant();
    end
  end

  always @(negedge clk_i) begin
    if (quiet_tail || !rst_ni) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_ready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Called and returning at a falling edge; valid stays high until the next call decides.
  task automatic send_item(input fpba_pkg::item_kind_e kind, input logic [5:0] idx,
                           input logic [fpba_pkg::CAP_W-1:0] cap,
                           input logic [fpba_pkg::CAP_W-1:0] size,
                           input logic last);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_load_index <= idx;
    in_load_capacity <= cap;
    in_request_size <= size;
    in_last <= last;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic send_load(input logic [5:0] idx, input logic [fpba_pkg::CAP_W-1:0] cap);
    send_item(fpba_pkg::KIND_LOAD, idx, cap, fpba_pkg::CAP_W'($urandom()), 1'($urandom()));
  endtask

  task automatic send_request(input logic [fpba_pkg::CAP_W-1:0] size, input logic last);
    send_item(fpba_pkg::KIND_REQUEST, 6'($urandom()), fpba_pkg::CAP_W'($urandom()), size, last);
  endtask

  // Waits until every grant is in and a load or request still in flight has finished.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (expected_grants.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_register(input fpba_pkg::reg_sel_e sel,
                                input logic [fpba_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= (sel == fpba_pkg::REG_BLOCKS_IN_USE) ? BIU_ADDR : POLICY_ADDR;
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (sel == fpba_pkg::REG_BLOCKS_IN_USE) model_blocks_in_use = value[fpba_pkg::BIU_W-1:0];
    else model_policy = value[fpba_pkg::POL_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Upper data bits are random; only the register's own width is kept.
  task automatic set_config(input logic [fpba_pkg::BIU_W-1:0] biu,
                            input logic [fpba_pkg::POL_W-1:0] pol);
    settle_block();
    write_register(fpba_pkg::REG_BLOCKS_IN_USE, ($urandom() & ~32'h7F) | 32'(biu));
    write_register(fpba_pkg::REG_FIT_POLICY, ($urandom() & ~32'h3) | 32'(pol));
  endtask

  task automatic test_empty_table();
    send_request(16'd0, 1'b0);
    send_request(16'd1, 1'b1);
    send_request(16'hFFFF, 1'b0);
  endtask

  task automatic test_fit_policies();
    send_load(6'd0, 16'd5);
    send_load(6'd1, 16'd3);
    send_load(6'd2, 16'd8);
    send_load(6'd3, 16'd3);
    send_load(6'd5, 16'd8);
    send_load(6'd63, 16'hFFFF);
    send_request(16'd3, 1'b0);
    send_request(16'hFFFF, 1'b1);
    set_config(7'd64, fpba_pkg::FIT_BEST);
    send_request(16'd3, 1'b1);
    set_config(7'd64, fpba_pkg::FIT_WORST);
    send_request(16'd4, 1'b0);
    set_config(7'd64, FIT_UNUSED);
    send_request(16'd1, 1'b1);
  endtask

  task automatic test_scan_length();
    set_config(7'd0, fpba_pkg::FIT_FIRST);
    send_request(16'd0, 1'b1);
    set_config(7'd1, fpba_pkg::FIT_WORST);
    send_request(16'd1, 1'b0);
    send_load(6'd63, 16'hFFFF);
    set_config(7'd127, fpba_pkg::FIT_FIRST);
    send_request(16'hFFFF, 1'b1);
    set_config(7'd64, fpba_pkg::FIT_BEST);
    send_request(16'd0, 1'b0);
  endtask

  // Narrow phases keep capacities small so that ties and exact fits are common.
  task automatic run_random_phase(input int count, input bit narrow);
    logic [fpba_pkg::BIU_W-1:0] biu;
    logic [5:0]                 idx;
    logic [fpba_pkg::CAP_W-1:0] size;
    case ($urandom_range(0, 6))
      0: biu = 7'd0;
      1: biu = 7'd1;
      2: biu = 7'd64;
      3: biu = fpba_pkg::BIU_W'($urandom_range(65, 127));
      default: biu = fpba_pkg::BIU_W'($urandom_range(1, 64));
    endcase
    set_config(biu, fpba_pkg::POL_W'($urandom_range(0, 3)));
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 99) < 35) begin
        idx = 6'($urandom_range(0, 63));
        if (biu > 1 && biu < 64 && $urandom_range(0, 1) == 1)
          idx = 6'($urandom_range(0, int'(biu) - 1));
        send_load(idx, narrow ? fpba_pkg::CAP_W'($urandom_range(0, 31))
                              : fpba_pkg::CAP_W'($urandom()));
      end else begin
        size = narrow ? fpba_pkg::CAP_W'($urandom_range(0, 24))
                      : fpba_pkg::CAP_W'($urandom() >> $urandom_range(16, 31));
        send_request(size, $urandom_range(0, 7) == 0);
      end
      random_items++;
    end
  endtask

  task automatic test_random_traffic();
    while (random_items < 650)
      run_random_phase($urandom_range(60, 130), 1'($urandom()));
  endtask

  task automatic test_steady_stream();
    settle_block();
    quiet_tail = 1'b1;
    run_random_phase(50, 1'b1);
  endtask

  initial begin
    for (int i = 0; i < fpba_pkg::BLOCKS; i++) capacity_model[i] = '0;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_table();
    test_fit_policies();
    test_scan_length();
    test_random_traffic();
    test_steady_stream();
    settle_block();
    if (errors == 0) begin
      $display("fit_policy_block_allocator verification clean");
    end else begin
      $display("fit_policy_block_allocator verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
+incdir+sv
sv/fpba_pkg.sv
sv/fpba_cell.sv
sv/fit_policy_block_allocator.sv
tb/fit_policy_block_allocator_test.sv
